// ----- hdl/smp_pkg.sv -----
// Shared types and constants for the serial-loaded PRG bank mapper.
// No dependencies; imported by the mapper, RAM and top-level modules.
`timescale 1ns / 1ps

package smp_pkg;

  typedef enum logic [1:0] {
    OUT_ROM   = 2'd0,
    OUT_RAM   = 2'd1,
    OUT_WRITE = 2'd2,
    OUT_ERROR = 2'd3
  } outcome_e;

  // bank modes, as committed from control bits 3:2
  localparam logic [1:0] MODE_32K_A     = 2'd0;
  localparam logic [1:0] MODE_32K_B     = 2'd1;
  localparam logic [1:0] MODE_FIX_LOW   = 2'd2;
  localparam logic [1:0] MODE_FIX_HIGH  = 2'd3;

  // commit targets, by address bits 15:13 of the fifth write
  localparam logic [2:0] REG_CONTROL = 3'b100;
  localparam logic [2:0] REG_PRG     = 3'b111;
  localparam logic [2:0] REG_RAM     = 3'b011;

  localparam logic [15:0] RAM_BASE = 16'h6000;

  localparam logic [2:0] SERIAL_LAST = 3'd4;

  localparam logic [4:0] RESET_BANK_COUNT = 5'd2;
  localparam logic [3:0] RESET_HIGH_BANK  = 4'(RESET_BANK_COUNT - 5'd1);

  typedef struct packed {
    logic        we;
    logic        re;
    logic [15:0] offset;
    logic [7:0]  wdata;
  } ram_cmd_t;

  typedef struct packed {
    outcome_e    outcome;
    logic [17:0] rom_offset;
    logic        ram_read;
  } result_t;

endpackage

// ----- hdl/smp_req_if.sv -----
// Request channel: one CPU bus access per request.
// Plain valid/ready handshake; no package dependencies.
`timescale 1ns / 1ps

interface smp_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] bus_address;
  logic [7:0]  write_data;

  modport source (output valid, action, bus_address, write_data, input ready);
  modport sink   (input valid, action, bus_address, write_data, output ready);
endinterface

// ----- hdl/smp_rsp_if.sv -----
// Response channel: one result per bus access.
// Plain valid/ready handshake; no package dependencies.
`timescale 1ns / 1ps

interface smp_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  outcome;
  logic [17:0] rom_offset;
  logic [7:0]  read_data;

  modport source (output valid, outcome, rom_offset, read_data, input ready);
  modport sink   (input valid, outcome, rom_offset, read_data, output ready);
endinterface

// ----- hdl/serial_loaded_prg_bank_mapper_unit.sv -----
// Usage
//   req_i carries one CPU bus access per request (action, bus_address,
//   write_data); rsp_o returns one result per request (outcome, rom_offset,
//   read_data). The user must load the bank count register (cfg_we_i,
//   cfg_wdata_i) only while no request is in flight; the block never checks.
//   The result is registered and shows in the cycle after the request is
//   taken. Throughput is one request per cycle; all decode and state
//   update sit between the request port and the result register, and RAM
//   reads come from the single RAM port's registered read.
//   A stalled response holds its register; a new request is still taken in
//   the cycle the held result is taken, otherwise ready drops.
//   After reset the PRG RAM is zeroed by a sweep over all RAM_BYTES bytes
//   (8192 by default), one byte a cycle; req_i.ready stays low until it
//   completes. Configuration writes are taken during the sweep.
// Depends on smp_pkg, smp_req_if, smp_rsp_if, smp_mapper and smp_ram.
`timescale 1ns / 1ps

module serial_loaded_prg_bank_mapper_unit import smp_pkg::*; #(
  parameter int RAM_BYTES = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  smp_req_if.sink     req_i,
  smp_rsp_if.source   rsp_o
);

  logic       accept;
  logic       clearing;
  logic       rsp_valid_q;
  result_t    result;
  result_t    result_q;
  ram_cmd_t   ram_cmd;
  logic [7:0] ram_rd_data;

  assign req_i.ready = !clearing && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  smp_mapper u_mapper (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .action_i      (req_i.action),
    .bus_address_i (req_i.bus_address),
    .write_data_i  (req_i.write_data),
    .ram_cmd_o     (ram_cmd),
    .result_o      (result)
  );

  smp_ram #(
    .RAM_BYTES (RAM_BYTES)
  ) u_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (ram_cmd),
    .rd_data_o  (ram_rd_data),
    .clearing_o (clearing)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (accept) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.outcome    = result_q.outcome;
  assign rsp_o.rom_offset = result_q.rom_offset;
  // RAM read data lands in the RAM's own output register with the request
  assign rsp_o.read_data  = result_q.ram_read ? ram_rd_data : 8'h00;

endmodule

// ----- hdl/smp_mapper.sv -----
// Mapper state (serial shift register, bank windows, mode, RAM enable) and
// address decode for one access. Depends on smp_pkg.
`timescale 1ns / 1ps

module smp_mapper import smp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        accept_i,
  input  logic        action_i,
  input  logic [15:0] bus_address_i,
  input  logic [7:0]  write_data_i,
  output ram_cmd_t    ram_cmd_o,
  output result_t     result_o
);

  logic [4:0] bank_count_q;
  logic [4:0] bits_q, bits_d;
  logic [2:0] count_q, count_d;
  logic [1:0] mode_q, mode_d;
  logic [3:0] low_q, low_d;
  logic [3:0] high_q, high_d;
  logic       ram_en_q, ram_en_d;

  logic       ram_hit, rom_hit;
  logic [3:0] last_bank;
  logic [4:0] shifted;
  logic [3:0] prg_bank;
  logic [3:0] rd_bank;

  assign ram_hit   = (bus_address_i[15:13] == REG_RAM);
  assign rom_hit   = bus_address_i[15];
  assign last_bank = bank_count_q[3:0] - 4'd1;
  assign shifted   = bits_q | ({4'b0, write_data_i[0]} << count_q);
  assign prg_bank  = shifted[3:0];

  always_comb begin
    bits_d   = bits_q;
    count_d  = count_q;
    mode_d   = mode_q;
    low_d    = low_q;
    high_d   = high_q;
    ram_en_d = ram_en_q;
    if (accept_i && rom_hit && action_i) begin
      if (write_data_i[7]) begin
        bits_d  = '0;
        count_d = '0;
        low_d   = '0;
        high_d  = last_bank;
      end else if (count_q == SERIAL_LAST) begin
        bits_d  = '0;
        count_d = '0;
        case (bus_address_i[15:13])
          REG_CONTROL: begin
            mode_d = shifted[3:2];
          end
          REG_PRG: begin
            unique case (mode_q) inside
              MODE_32K_A, MODE_32K_B: begin
                low_d  = {prg_bank[3:1], 1'b0};
                high_d = {prg_bank[3:1], 1'b1};
              end
              MODE_FIX_LOW: begin
                low_d  = '0;
                high_d = prg_bank;
              end
              MODE_FIX_HIGH: begin
                low_d  = prg_bank;
                high_d = last_bank;
              end
              default: begin
                low_d  = low_q;
                high_d = high_q;
              end
            endcase
            ram_en_d = ~shifted[4];
          end
          default: begin
            mode_d = mode_q;  // CHR registers: not modeled
          end
        endcase
      end else begin
        bits_d  = shifted;
        count_d = count_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_count_q <= RESET_BANK_COUNT;
      bits_q       <= '0;
      count_q      <= '0;
      mode_q       <= MODE_FIX_HIGH;
      low_q        <= '0;
      high_q       <= RESET_HIGH_BANK;
      ram_en_q     <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        bank_count_q <= cfg_wdata_i;
      end
      bits_q   <= bits_d;
      count_q  <= count_d;
      mode_q   <= mode_d;
      low_q    <= low_d;
      high_q   <= high_d;
      ram_en_q <= ram_en_d;
    end
  end

  // result of the access, from state as it stood before this request
  assign rd_bank = bus_address_i[14] ? high_q : low_q;

  always_comb begin
    result_o.outcome    = OUT_ERROR;
    result_o.rom_offset = '0;
    result_o.ram_read   = 1'b0;
    if (ram_hit) begin
      if (ram_en_q) begin
        result_o.outcome  = action_i ? OUT_WRITE : OUT_RAM;
        result_o.ram_read = ~action_i;
      end
    end else if (rom_hit) begin
      if (action_i) begin
        result_o.outcome = OUT_WRITE;
      end else begin
        result_o.outcome    = OUT_ROM;
        result_o.rom_offset = {rd_bank, bus_address_i[13:0]};
      end
    end
  end

  assign ram_cmd_o.we     = accept_i && ram_hit && ram_en_q && action_i;
  assign ram_cmd_o.re     = accept_i && ram_hit && ram_en_q && !action_i;
  assign ram_cmd_o.offset = bus_address_i - RAM_BASE;
  assign ram_cmd_o.wdata  = write_data_i;

endmodule

// ----- hdl/smp_ram.sv -----
// PRG work RAM, single port, registered read, with a zeroing sweep after
// reset. Depends on smp_pkg.
`timescale 1ns / 1ps

module smp_ram import smp_pkg::*; #(
  parameter int RAM_BYTES = 8192
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ram_cmd_t   cmd_i,
  output logic [7:0] rd_data_o,
  output logic       clearing_o
);

  localparam int              AW   = $clog2(RAM_BYTES);
  localparam logic [AW-1:0]   LAST = AW'(RAM_BYTES - 1);

  logic [7:0]    mem [RAM_BYTES];
  logic [AW-1:0] clr_cnt_q;
  logic          clearing_q;
  logic [7:0]    rd_q;
  logic [AW-1:0] addr;

  assign addr = cmd_i.offset[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clearing_q <= 1'b1;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == LAST) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (cmd_i.we) begin
      mem[addr] <= cmd_i.wdata;
    end
    if (cmd_i.re) begin
      rd_q <= mem[addr];
    end
  end

  assign rd_data_o  = rd_q;
  assign clearing_o = clearing_q;

endmodule

// ----- tb/smp_checker.sv -----
// Scoreboard for the serial-loaded PRG bank mapper: watches the request,
// result and bank-count ports, predicts each result and compares it.
// Depends on smp_pkg, smp_req_if and smp_rsp_if.
`timescale 1ns / 1ps

module smp_checker import smp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  smp_req_if         req_i,
  smp_rsp_if         rsp_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o
);

  localparam int RamBytes = 8192;

  typedef struct packed {
    outcome_e    outcome;
    logic [17:0] rom_offset;
    logic [7:0]  read_data;
  } access_result_t;

  access_result_t expected_results[$];

  // mirror of the mapper state
  logic [7:0] prg_ram [RamBytes];
  logic [4:0] bank_count;
  logic [4:0] shift_bits;
  logic [2:0] shift_count;
  logic [1:0] bank_mode;
  logic [3:0] low_bank;
  logic [3:0] high_bank;
  logic       ram_on;

  // last bank of the cartridge, wrapped to 4 bits
  function automatic logic [3:0] fixed_bank();
    return 4'(bank_count + 5'd15);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count_o++;
  endtask

  task automatic predict_access(input logic is_write, input logic [15:0] addr,
                                input logic [7:0] data, output access_result_t res);
    logic [4:0] value;
    logic [3:0] sel;
    res.outcome    = OUT_ERROR;
    res.rom_offset = '0;
    res.read_data  = '0;
    if (addr >= RAM_BASE && !addr[15]) begin
      if (ram_on) begin
        if (is_write) begin
          prg_ram[addr[12:0]] = data;
          res.outcome = OUT_WRITE;
        end else begin
          res.read_data = prg_ram[addr[12:0]];
          res.outcome = OUT_RAM;
        end
      end
    end else if (addr[15]) begin
      if (is_write) begin
        res.outcome = OUT_WRITE;
        if (data[7]) begin
          shift_bits  = '0;
          shift_count = '0;
          low_bank    = '0;
          high_bank   = fixed_bank();
        end else begin
          value = shift_bits | (5'(data[0]) << shift_count);
          if (shift_count == SERIAL_LAST) begin
            // fifth bit: target picked by the address of this write
            case (addr[15:13])
              REG_CONTROL: bank_mode = value[3:2];
              REG_PRG: begin
                case (bank_mode)
                  MODE_32K_A, MODE_32K_B: begin
                    low_bank  = {value[3:1], 1'b0};
                    high_bank = {value[3:1], 1'b1};
                  end
                  MODE_FIX_LOW: begin
                    low_bank  = '0;
                    high_bank = value[3:0];
                  end
                  default: begin
                    low_bank  = value[3:0];
                    high_bank = fixed_bank();
                  end
                endcase
                ram_on = !value[4];
              end
              default: ;  // CHR registers: no visible effect
            endcase
            shift_bits  = '0;
            shift_count = '0;
          end else begin
            shift_bits  = value;
            shift_count = shift_count + 3'd1;
          end
        end
      end else begin
        sel = addr[14] ? high_bank : low_bank;
        res.outcome    = OUT_ROM;
        res.rom_offset = {sel, addr[13:0]};
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    access_result_t got;
    access_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < RamBytes; i++) prg_ram[i] = '0;
      bank_count   = RESET_BANK_COUNT;
      shift_bits   = '0;
      shift_count  = '0;
      bank_mode    = MODE_FIX_HIGH;
      low_bank     = '0;
      high_bank    = RESET_HIGH_BANK;
      ram_on       = 1'b1;
      expected_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (cfg_we_i) bank_count = cfg_wdata_i;
      // results are compared before the request of this edge is predicted
      if (rsp_i.valid && rsp_i.ready) begin
        got.outcome    = outcome_e'(rsp_i.outcome);
        got.rom_offset = rsp_i.rom_offset;
        got.read_data  = rsp_i.read_data;
        if (expected_results.size() == 0) begin
          report_mismatch("unrequested result", 32'(got), '0);
        end else begin
          want = expected_results.pop_front();
          if (got.outcome != want.outcome)
            report_mismatch("outcome", 32'(got.outcome), 32'(want.outcome));
          if (got.rom_offset != want.rom_offset)
            report_mismatch("rom_offset", 32'(got.rom_offset), 32'(want.rom_offset));
          if (got.read_data != want.read_data)
            report_mismatch("read_data", 32'(got.read_data), 32'(want.read_data));
          checked_o++;
        end
      end
      if (req_i.valid && req_i.ready) begin
        predict_access(req_i.action, req_i.bus_address, req_i.write_data, want);
        expected_results.push_back(want);
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
// Top of the mapper testbench: clock, reset, bank-count settings and bus
// request stimulus; the verdict comes from smp_checker.
// Depends on smp_pkg, smp_req_if, smp_rsp_if, smp_checker and the mapper unit.
`timescale 1ns / 1ps

module tb;
  import smp_pkg::*;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 175;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [15:0] CONTROL_BASE = 16'h8000;
  localparam logic [15:0] CHR_BASE     = 16'hA000;
  localparam logic [15:0] PRG_BASE     = 16'hE000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int checked;
  int sent_count = 0;
  int cycle_count = 0;
  int src_idle_pct = 10;
  int sink_idle_pct = 10;
  bit calm_tail = 1'b0;

  logic [4:0] bank_settings [NUM_PHASES];

  smp_req_if req_bus ();
  smp_rsp_if rsp_bus ();

  serial_loaded_prg_bank_mapper_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  smp_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .req_i        (req_bus),
    .rsp_i        (rsp_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    int hold;
    hold = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        rsp_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < sink_idle_pct) begin
        hold = $urandom_range(1, 19) - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  function automatic int idle_choice();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  function automatic logic [15:0] rom_addr();
    return 16'($urandom_range(32'h8000, 32'hFFFF));
  endfunction

  function automatic logic [15:0] ram_addr();
    case ($urandom_range(0, 3))
      0, 1: return RAM_BASE + 16'($urandom_range(0, 15));
      2: return 16'h7FF0 + 16'($urandom_range(0, 15));
      default: return RAM_BASE + 16'($urandom_range(0, 16'h1FFF));
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_access(input logic act, input logic [15:0] addr,
                             input logic [7:0] data);
    if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    req_bus.valid       <= 1'b1;
    req_bus.action      <= act;
    req_bus.bus_address <= addr;
    req_bus.write_data  <= data;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
    sent_count++;
    if (sent_count % 48 == 0 && !calm_tail) begin
      src_idle_pct  = idle_choice();
      sink_idle_pct = idle_choice();
    end
  endtask

  // five serial writes, LSB first; only the last address picks the target
  task automatic serial_load(input logic [15:0] target, input logic [4:0] value);
    logic [15:0] addr;
    for (int i = 0; i < 5; i++) begin
      addr = (i == 4) ? target : rom_addr();
      send_access(ACT_WRITE, addr, {1'b0, 6'($urandom), value[i]});
      if (i < 4 && $urandom_range(0, 9) == 0)
        send_access(ACT_READ, rom_addr(), 8'($urandom));
    end
  endtask

  task automatic write_bank_count(input logic [4:0] value);
    req_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_burst();
    int kind;
    int sel;
    logic [15:0] target;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      sel = $urandom_range(0, 2);
      case (sel)
        0: target = CONTROL_BASE + 16'($urandom_range(0, 16'h1FFF));
        1: target = CHR_BASE + 16'($urandom_range(0, 16'h3FFF));
        default: target = PRG_BASE + 16'($urandom_range(0, 16'h1FFF));
      endcase
      if ($urandom_range(0, 9) == 0) begin
        // sequence cut short by a clearing write
        repeat ($urandom_range(0, 4))
          send_access(ACT_WRITE, rom_addr(), {1'b0, 7'($urandom)});
        send_access(ACT_WRITE, rom_addr(), {1'b1, 7'($urandom)});
      end else begin
        serial_load(target, 5'($urandom));
      end
    end else if (kind < 55) begin
      send_access(ACT_READ, rom_addr(), 8'($urandom));
    end else if (kind < 75) begin
      send_access(1'($urandom), ram_addr(), 8'($urandom));
    end else if (kind < 83) begin
      send_access(ACT_WRITE, rom_addr(), {1'b1, 7'($urandom)});
    end else begin
      send_access(1'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int phase_start;
    req_bus.valid       = 1'b0;
    req_bus.action      = ACT_READ;
    req_bus.bus_address = '0;
    req_bus.write_data  = '0;

    bank_settings[0] = 5'd16;
    bank_settings[1] = 5'd1;
    bank_settings[2] = 5'd0;
    bank_settings[3] = 5'd31;
    bank_settings[4] = 5'($urandom_range(3, 15));
    bank_settings[5] = 5'd2;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) begin
        calm_tail     = 1'b1;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      write_bank_count(bank_settings[p]);
      if (p == 0) begin
        // windows still hold the reset layout after the count change
        send_access(ACT_READ, 16'h0000, 8'h00);
        send_access(ACT_WRITE, 16'h5FFF, 8'hFF);
        send_access(ACT_WRITE, RAM_BASE, 8'hA5);
        send_access(ACT_WRITE, 16'h7FFF, 8'h5A);
        send_access(ACT_READ, RAM_BASE, 8'h00);
        send_access(ACT_READ, 16'h7FFF, 8'hFF);
        send_access(ACT_READ, 16'h8000, 8'h00);
        send_access(ACT_READ, 16'hFFFF, 8'h00);
        send_access(ACT_WRITE, 16'hC000, 8'h80);
        send_access(ACT_READ, 16'hFFFF, 8'h00);
        serial_load(16'h9FFF, 5'h08);
        serial_load(16'hFFFF, 5'h1F);
        send_access(ACT_READ, RAM_BASE, 8'h00);
        send_access(ACT_WRITE, 16'h7000, 8'h3C);
        send_access(ACT_READ, 16'hC000, 8'h00);
        send_access(ACT_READ, 16'hBFFF, 8'h00);
      end
      phase_start = sent_count;
      while (sent_count - phase_start < PHASE_ITEMS) random_burst();
    end

    req_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("Sent %0d bus accesses over %0d bank-count settings (16, 1, 0, 31, %0d, 2).",
             sent_count, NUM_PHASES, bank_settings[4]);
    $display("Compared %0d results; %0d field mismatches.", checked, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
